/* src/blhr_pkg.sv */
// Shared types, register map and color codes for the highlight rebuild block.
package blhr_pkg;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOAD = 8'b0000_0010,
    ST_SQ   = 8'b0000_0100,
    ST_XM   = 8'b0000_1000,
    ST_ROOT = 8'b0001_0000,
    ST_FIN  = 8'b0010_0000,
    ST_OUT1 = 8'b0100_0000,
    ST_OUT2 = 8'b1000_0000
  } state_t;

  localparam logic [2:0] REG_CLIP   = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_CFA    = 3'd3;
  localparam logic [2:0] REG_OFFX   = 3'd4;
  localparam logic [2:0] REG_OFFY   = 3'd5;

  localparam logic [1:0] CFA_R    = 2'd0;
  localparam logic [1:0] CFA_G    = 2'd1;
  localparam logic [1:0] CFA_B    = 2'd2;
  localparam logic [1:0] CFA_NONE = 2'd3;

  localparam logic [19:0] CLIP_RST   = 20'd65536;
  localparam logic [12:0] DIM_RST    = 13'd4096;
  localparam logic [31:0] CFA_RST    = 32'h9494_9494;
  localparam logic [27:0] RECIP3     = 28'd178956971;
  localparam logic [4:0]  ROOT_MSB   = 5'd24;

  function automatic logic [1:0] cfa_color(input logic [31:0] pat, input logic [2:0] rr,
                                           input logic cc);
    return pat[{rr, cc, 1'b0} +: 2];
  endfunction

endpackage

/* src/blhr_ram.sv */
// Generic single-port-write, registered-read RAM.
module blhr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/bayer_lch_highlight_rebuild.sv */
// Bayer LCh highlight rebuild: line buffer, block classification and iterative rebuild.
// A word is accepted in IDLE and classified in LOAD; its outputs leave through OUT1 and OUT2.
// A rebuild first runs SQ, XM, ROOT and FIN on the shared multiplier and the root loop (5 squares,
// 4 partial products, 25 root bits, 1 scale step). A new word is taken only back in IDLE.
// Reset: registers go to their defaults, position and left samples to zero; the line store
// is not cleared.
module bayer_lch_highlight_rebuild #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_pixel_value,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_pixel_out,
  output logic [11:0] out_row,
  output logic [11:0] out_col,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WCAP = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam logic [12:0] WCAP13 = 13'(WCAP);
  localparam logic [19:0] SMAX =
    (SAMPLE_BITS >= 20) ? 20'hF_FFFF : 20'((64'd1 << SAMPLE_BITS) - 64'd1);

  blhr_pkg::state_t state_r, state_nxt;

  logic [19:0] clip_r;
  logic [12:0] fwidth_r, fheight_r;
  logic [31:0] cfa_r;
  logic [11:0] offx_r, offy_r;

  logic [11:0] row_r, col_r, pr_r, pc_r;
  logic [19:0] left_prev_r, left_cur_r, v_r;
  logic [19:0] rv_r, gmin_r, gmax_r, bv_r, res_r, edge_r;
  logic [1:0]  own_r;
  logic        emit2_r, ksign_r;
  logic [2:0]  sq_cnt_r;
  logic [1:0]  xm_cnt_r;
  logic [4:0]  bit_r;
  logic [45:0] tmp_r, dsum_r, nsum_r, kk_r;
  logic [95:0] x_r, p_r, q_r;
  logic [24:0] y_r;

  logic        out_valid_r, out_last_r;
  logic [19:0] out_pix_r;
  logic [11:0] out_row_r, out_col_r;

  logic        acc, wr_en, out_free;
  logic [12:0] w_eff, h_eff, c0, r0, c1, r1;
  logic [11:0] r2;
  logic [19:0] above;
  logic [2:0]  cfg_idx;

  assign pready   = 1'b1;
  assign cfg_idx  = paddr[4:2];
  assign wr_en    = psel && penable && pwrite;
  assign in_ready = (state_r == blhr_pkg::ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_last_of_run = out_last_r;

  always_comb begin
    case (cfg_idx)
      blhr_pkg::REG_CLIP:   prdata = {12'd0, clip_r};
      blhr_pkg::REG_WIDTH:  prdata = {19'd0, fwidth_r};
      blhr_pkg::REG_HEIGHT: prdata = {19'd0, fheight_r};
      blhr_pkg::REG_CFA:    prdata = cfa_r;
      blhr_pkg::REG_OFFX:   prdata = {20'd0, offx_r};
      blhr_pkg::REG_OFFY:   prdata = {20'd0, offy_r};
      default:              prdata = 32'd0;
    endcase
  end

  assign w_eff = (fwidth_r < 13'd2) ? 13'd2 : ((fwidth_r > WCAP13) ? WCAP13 : fwidth_r);
  assign h_eff = (fheight_r < 13'd2) ? 13'd2 : ((fheight_r > 13'd4096) ? 13'd4096 : fheight_r);

  // normalize the position of the incoming word
  always_comb begin
    c0 = in_frame_start ? 13'd0 : {1'b0, col_r};
    r0 = in_frame_start ? 13'd0 : {1'b0, row_r};
    if (c0 >= w_eff) begin
      c1 = 13'd0;
      r1 = r0 + 13'd1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h_eff) ? 12'd0 : r1[11:0];
  end

  blhr_ram #(.WIDTH(20), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (state_r == blhr_pkg::ST_LOAD),
    .waddr (AW'(pc_r)),
    .wdata (v_r),
    .re    (acc),
    .raddr (AW'(c1[11:0])),
    .rdata (above)
  );

  // block classification
  logic [19:0] blk [4];
  logic [1:0]  bcol [4];
  logic [2:0]  rt3, rb3;
  logic        cl1, cr1;
  logic [19:0] sel_r, sel_b, sel_gmin, sel_gmax, direct_res, own_val;
  logic        clipped, green, emit1, emit2, need_calc;
  logic [1:0]  own;
  logic [12:0] nc, nr;

  always_comb begin
    blk[0] = left_prev_r;
    blk[1] = above;
    blk[2] = left_cur_r;
    blk[3] = v_r;
    rt3 = pr_r[2:0] - 3'd1 + offy_r[2:0];
    rb3 = pr_r[2:0] + offy_r[2:0];
    cl1 = ~pc_r[0] ^ offx_r[0];
    cr1 = pc_r[0] ^ offx_r[0];
    bcol[0] = blhr_pkg::cfa_color(cfa_r, rt3, cl1);
    bcol[1] = blhr_pkg::cfa_color(cfa_r, rt3, cr1);
    bcol[2] = blhr_pkg::cfa_color(cfa_r, rb3, cl1);
    bcol[3] = blhr_pkg::cfa_color(cfa_r, rb3, cr1);
    sel_r = 20'd0;
    sel_b = 20'd0;
    sel_gmin = 20'd0;
    sel_gmax = 20'd0;
    clipped = 1'b0;
    green = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (blk[i] > clip_r) begin
        clipped = 1'b1;
      end
      case (bcol[i])
        blhr_pkg::CFA_R: sel_r = blk[i];
        blhr_pkg::CFA_B: sel_b = blk[i];
        blhr_pkg::CFA_G: begin
          if (!green) begin
            sel_gmin = blk[i];
            sel_gmax = blk[i];
            green = 1'b1;
          end else begin
            if (blk[i] < sel_gmin) sel_gmin = blk[i];
            if (blk[i] > sel_gmax) sel_gmax = blk[i];
          end
        end
        default: ;
      endcase
    end
    own = bcol[0];
    case (own)
      blhr_pkg::CFA_R: own_val = sel_r;
      blhr_pkg::CFA_G: own_val = sel_gmax;
      default:         own_val = sel_b;
    endcase
    need_calc = 1'b0;
    if (!clipped) begin
      direct_res = blk[0];
    end else if (own == blhr_pkg::CFA_NONE) begin
      direct_res = 20'd0;
    end else if (sel_r == sel_gmax || sel_gmax == sel_b) begin
      direct_res = (own_val > SMAX) ? SMAX : own_val;
    end else begin
      direct_res = 20'd0;
      need_calc = 1'b1;
    end
    emit1 = (pr_r != 12'd0) && (pc_r != 12'd0);
    emit2 = ({1'b0, pc_r} == w_eff - 13'd1) || ({1'b0, pr_r} == h_eff - 13'd1);
    nc = {1'b0, pc_r} + 13'd1;
    nr = {1'b0, pr_r} + 13'd1;
  end

  // rebuild arithmetic
  logic [19:0] ro, go, bo;
  logic signed [22:0] d_s, e_s, a_s, b_s;
  logic signed [24:0] d3, e25, k_s;
  logic [22:0] dm, em, am, bm, km, opa, opb;
  logic [45:0] prod;
  logic [5:0]  xsh;
  logic [95:0] d96, cand;
  logic [21:0] sum22;
  logic signed [27:0] t_s;
  logic [26:0] x27;
  logic [54:0] q55;
  logic [25:0] q26;
  logic [19:0] fin_res;

  always_comb begin
    ro = (rv_r < clip_r) ? rv_r : clip_r;
    go = (gmin_r < clip_r) ? gmin_r : clip_r;
    bo = (bv_r < clip_r) ? bv_r : clip_r;
    d_s = $signed({3'b0, rv_r}) - $signed({3'b0, gmax_r});
    e_s = $signed({2'b0, bv_r, 1'b0}) - $signed({3'b0, gmax_r}) - $signed({3'b0, rv_r});
    a_s = $signed({3'b0, ro}) - $signed({3'b0, go});
    b_s = $signed({2'b0, bo, 1'b0}) - $signed({3'b0, go}) - $signed({3'b0, ro});
    d3  = ($signed({{2{d_s[22]}}, d_s}) <<< 1) + $signed({{2{d_s[22]}}, d_s});
    e25 = $signed({{2{e_s[22]}}, e_s});
    case (own_r)
      blhr_pkg::CFA_R: k_s = d3 - e25;
      blhr_pkg::CFA_G: k_s = 25'sd0 - d3 - e25;
      default:         k_s = e25 <<< 1;
    endcase
    dm = d_s[22] ? 23'(-d_s) : 23'(d_s);
    em = e_s[22] ? 23'(-e_s) : 23'(e_s);
    am = a_s[22] ? 23'(-a_s) : 23'(a_s);
    bm = b_s[22] ? 23'(-b_s) : 23'(b_s);
    km = k_s[24] ? 23'(-k_s) : 23'(k_s);
    if (state_r == blhr_pkg::ST_XM) begin
      opa = xm_cnt_r[1] ? kk_r[45:23] : kk_r[22:0];
      opb = xm_cnt_r[0] ? nsum_r[45:23] : nsum_r[22:0];
    end else begin
      case (sq_cnt_r)
        3'd0:    opa = dm;
        3'd1:    opa = em;
        3'd2:    opa = am;
        3'd3:    opa = bm;
        default: opa = km;
      endcase
      opb = opa;
    end
    prod = opa * opb;
    case (xm_cnt_r)
      2'd0:    xsh = 6'd0;
      2'd3:    xsh = 6'd46;
      default: xsh = 6'd23;
    endcase
    d96  = 96'(dsum_r);
    cand = p_r + (q_r << ({1'b0, bit_r} + 6'd1)) + (d96 << {bit_r, 1'b0});
    sum22 = 22'(rv_r) + 22'(gmax_r) + 22'(bv_r);
    t_s = ksign_r ? ($signed({5'b0, sum22, 1'b0}) - $signed({3'b0, y_r}))
                  : ($signed({5'b0, sum22, 1'b0}) + $signed({3'b0, y_r}));
    x27 = 27'((t_s + 28'sd3) >>> 1);
    q55 = 55'(x27) * 55'(blhr_pkg::RECIP3);
    q26 = q55[54:29];
    if (t_s <= 28'sd0) begin
      fin_res = 20'd0;
    end else if (q26 > 26'(SMAX)) begin
      fin_res = SMAX;
    end else begin
      fin_res = q26[19:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blhr_pkg::ST_IDLE: if (acc) state_nxt = blhr_pkg::ST_LOAD;
      blhr_pkg::ST_LOAD: begin
        if (emit1 && need_calc) state_nxt = blhr_pkg::ST_SQ;
        else if (emit1)         state_nxt = blhr_pkg::ST_OUT1;
        else if (emit2)         state_nxt = blhr_pkg::ST_OUT2;
        else                    state_nxt = blhr_pkg::ST_IDLE;
      end
      blhr_pkg::ST_SQ:   if (sq_cnt_r == 3'd4) state_nxt = blhr_pkg::ST_XM;
      blhr_pkg::ST_XM:   if (xm_cnt_r == 2'd3) state_nxt = blhr_pkg::ST_ROOT;
      blhr_pkg::ST_ROOT: if (bit_r == 5'd0) state_nxt = blhr_pkg::ST_FIN;
      blhr_pkg::ST_FIN:  state_nxt = blhr_pkg::ST_OUT1;
      blhr_pkg::ST_OUT1: begin
        if (out_free) state_nxt = emit2_r ? blhr_pkg::ST_OUT2 : blhr_pkg::ST_IDLE;
      end
      blhr_pkg::ST_OUT2: if (out_free) state_nxt = blhr_pkg::ST_IDLE;
      default:           state_nxt = blhr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blhr_pkg::ST_IDLE;
      clip_r      <= blhr_pkg::CLIP_RST;
      fwidth_r    <= blhr_pkg::DIM_RST;
      fheight_r   <= blhr_pkg::DIM_RST;
      cfa_r       <= blhr_pkg::CFA_RST;
      offx_r      <= 12'd0;
      offy_r      <= 12'd0;
      row_r       <= 12'd0;
      col_r       <= 12'd0;
      left_prev_r <= 20'd0;
      left_cur_r  <= 20'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        case (cfg_idx)
          blhr_pkg::REG_CLIP:   clip_r    <= pwdata[19:0];
          blhr_pkg::REG_WIDTH:  fwidth_r  <= pwdata[12:0];
          blhr_pkg::REG_HEIGHT: fheight_r <= pwdata[12:0];
          blhr_pkg::REG_CFA:    cfa_r     <= pwdata;
          blhr_pkg::REG_OFFX:   offx_r    <= pwdata[11:0];
          blhr_pkg::REG_OFFY:   offy_r    <= pwdata[11:0];
          default: ;
        endcase
      end
      if (state_r == blhr_pkg::ST_LOAD) begin
        left_prev_r <= above;
        left_cur_r  <= v_r;
        if (nc >= w_eff) begin
          col_r <= 12'd0;
          row_r <= (nr >= h_eff) ? 12'd0 : nr[11:0];
        end else begin
          col_r <= nc[11:0];
          row_r <= pr_r;
        end
      end
      if ((state_r == blhr_pkg::ST_OUT1 || state_r == blhr_pkg::ST_OUT2) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      blhr_pkg::ST_IDLE: begin
        if (acc) begin
          pr_r <= r2;
          pc_r <= c1[11:0];
          v_r  <= in_pixel_value & SMAX;
        end
      end
      blhr_pkg::ST_LOAD: begin
        rv_r     <= sel_r;
        bv_r     <= sel_b;
        gmin_r   <= sel_gmin;
        gmax_r   <= sel_gmax;
        own_r    <= own;
        emit2_r  <= emit2;
        res_r    <= direct_res;
        edge_r   <= (v_r < clip_r) ? v_r : clip_r;
        sq_cnt_r <= 3'd0;
      end
      blhr_pkg::ST_SQ: begin
        case (sq_cnt_r)
          3'd0:    tmp_r  <= prod;
          3'd1:    dsum_r <= tmp_r + (tmp_r << 1) + prod;
          3'd2:    tmp_r  <= prod;
          3'd3:    nsum_r <= tmp_r + (tmp_r << 1) + prod;
          default: begin
            kk_r     <= prod;
            ksign_r  <= k_s[24];
            xm_cnt_r <= 2'd0;
            x_r      <= 96'd0;
          end
        endcase
        sq_cnt_r <= sq_cnt_r + 3'd1;
      end
      blhr_pkg::ST_XM: begin
        x_r      <= x_r + (96'(prod) << xsh);
        xm_cnt_r <= xm_cnt_r + 2'd1;
        bit_r    <= blhr_pkg::ROOT_MSB;
        y_r      <= 25'd0;
        p_r      <= 96'd0;
        q_r      <= 96'd0;
      end
      blhr_pkg::ST_ROOT: begin
        if (cand <= x_r) begin
          y_r[bit_r] <= 1'b1;
          p_r        <= cand;
          q_r        <= q_r + (d96 << bit_r);
        end
        bit_r <= bit_r - 5'd1;
      end
      blhr_pkg::ST_FIN: res_r <= fin_res;
      blhr_pkg::ST_OUT1: begin
        if (out_free) begin
          out_pix_r  <= res_r;
          out_row_r  <= pr_r - 12'd1;
          out_col_r  <= pc_r - 12'd1;
          out_last_r <= !emit2_r;
        end
      end
      blhr_pkg::ST_OUT2: begin
        if (out_free) begin
          out_pix_r  <= edge_r;
          out_row_r  <= pr_r;
          out_col_r  <= pc_r;
          out_last_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* bench/blhr_checker.sv */
// Scoreboard for the highlight rebuild block: tracks registers, predicts words and compares.
module blhr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [19:0] in_pixel_value,
  input  logic        in_frame_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [19:0] out_pixel_out,
  input  logic [11:0] out_row,
  input  logic [11:0] out_col,
  input  logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [19:0] PIX_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [19:0] pix;
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
  } pix_word_t;

  pix_word_t   expected_pix[$];
  logic [19:0] clip_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [31:0] cfa_q;
  logic [11:0] offx_q;
  logic [11:0] offy_q;
  logic [19:0] row_buf [0:4095];
  int          pos_row;
  int          pos_col;
  logic [19:0] left_cur;
  logic [19:0] left_prev;

  function automatic logic [1:0] color_at(input logic [31:0] rr, input logic [31:0] cc);
    return cfa_q[{rr[2:0], cc[0], 1'b0} +: 2];
  endfunction

  function automatic logic [19:0] sat_pix(input longint v);
    if (v <= 0) return '0;
    if (v > longint'(PIX_MAX)) return PIX_MAX;
    return v[19:0];
  endfunction

  function automatic logic [19:0] rebuild_pix(input int p, input int q, input logic [19:0] blk [4]);
    longint      r, b, gmin, gmax, cl, ro, go, bo, d, e, a, bb, s, k, kk, t, y, cand;
    logic [127:0] tgt;
    logic [63:0] dd, nn;
    logic [1:0]  col, own;
    bit          clipped, grn;
    r = 0; b = 0; gmin = 0; gmax = 0; clipped = 0; grn = 0;
    for (int i = 0; i < 4; i++) begin
      col = color_at(32'(p + (i >> 1)) + 32'(offy_q), 32'(q + (i & 1)) + 32'(offx_q));
      if (blk[i] > clip_q) clipped = 1;
      if (col == blhr_pkg::CFA_R) r = blk[i];
      else if (col == blhr_pkg::CFA_B) b = blk[i];
      else if (col == blhr_pkg::CFA_G) begin
        if (!grn) begin
          gmin = blk[i]; gmax = blk[i]; grn = 1;
        end else begin
          if (blk[i] < gmin) gmin = blk[i];
          if (blk[i] > gmax) gmax = blk[i];
        end
      end
    end
    if (!clipped) return blk[0];
    own = color_at(32'(p) + 32'(offy_q), 32'(q) + 32'(offx_q));
    if (own == blhr_pkg::CFA_NONE) return '0;
    if (r == gmax || gmax == b) begin
      if (own == blhr_pkg::CFA_R) return sat_pix(r);
      if (own == blhr_pkg::CFA_G) return sat_pix(gmax);
      return sat_pix(b);
    end
    cl = clip_q;
    ro = r < cl ? r : cl;
    go = gmin < cl ? gmin : cl;
    bo = b < cl ? b : cl;
    d = r - gmax;
    e = 2 * b - gmax - r;
    a = ro - go;
    bb = 2 * bo - go - ro;
    dd = 3 * d * d + e * e;
    nn = 3 * a * a + bb * bb;
    s = r + gmax + b;
    k = (own == blhr_pkg::CFA_R) ? 3 * d - e : ((own == blhr_pkg::CFA_G) ? -3 * d - e : 2 * e);
    kk = k < 0 ? -k : k;
    tgt = 128'(kk * kk) * 128'(nn);
    y = 0;
    for (int bit_i = 24; bit_i >= 0; bit_i--) begin
      cand = y | (longint'(1) << bit_i);
      if (128'(cand * cand) * 128'(dd) <= tgt) y = cand;
    end
    t = 2 * s + (k < 0 ? -y : y);
    if (t <= 0) return '0;
    return sat_pix((t + 3) / 6);
  endfunction

  task automatic predict_pix(input logic [19:0] v, input logic fs);
    int          w, h, r, c, n;
    logic [19:0] above;
    logic [19:0] blk [4];
    pix_word_t   wd;
    w = width_q < 2 ? 2 : (width_q > 4096 ? 4096 : int'(width_q));
    h = height_q < 2 ? 2 : (height_q > 4096 ? 4096 : int'(height_q));
    n = 0;
    if (fs) begin
      pos_row = 0; pos_col = 0;
    end
    if (pos_col >= w) begin
      pos_col = 0; pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    r = pos_row;
    c = pos_col;
    above = row_buf[c];
    if (r >= 1 && c >= 1) begin
      blk[0] = left_prev; blk[1] = above; blk[2] = left_cur; blk[3] = v;
      wd.pix = rebuild_pix(r - 1, c - 1, blk);
      wd.row = 12'(r - 1); wd.col = 12'(c - 1); wd.last = 0;
      expected_pix.push_back(wd);
      n++;
    end
    if (c == w - 1 || r == h - 1) begin
      wd.pix = v < clip_q ? v : clip_q;
      wd.row = 12'(r); wd.col = 12'(c); wd.last = 0;
      expected_pix.push_back(wd);
      n++;
    end
    if (n > 0) expected_pix[$].last = 1;
    left_prev = above;
    left_cur = v;
    row_buf[c] = v;
    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      clip_q = blhr_pkg::CLIP_RST; width_q = blhr_pkg::DIM_RST; height_q = blhr_pkg::DIM_RST;
      cfa_q = blhr_pkg::CFA_RST; offx_q = '0; offy_q = '0;
      pos_row = 0; pos_col = 0; left_cur = '0; left_prev = '0;
      expected_pix.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          blhr_pkg::REG_CLIP:   clip_q = pwdata[19:0];
          blhr_pkg::REG_WIDTH:  width_q = pwdata[12:0];
          blhr_pkg::REG_HEIGHT: height_q = pwdata[12:0];
          blhr_pkg::REG_CFA:    cfa_q = pwdata;
          blhr_pkg::REG_OFFX:   offx_q = pwdata[11:0];
          blhr_pkg::REG_OFFY:   offy_q = pwdata[11:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_pix(in_pixel_value, in_frame_start);
      if (out_valid && out_ready) begin
        if (expected_pix.size() == 0) begin
          report_mismatch($sformatf("unexpected word pix=%h at (%0d,%0d)",
                                    out_pixel_out, out_row, out_col));
        end else begin
          pix_word_t wd;
          wd = expected_pix.pop_front();
          if (out_pixel_out !== wd.pix || out_row !== wd.row || out_col !== wd.col ||
              out_last_of_run !== wd.last)
            report_mismatch($sformatf("got pix=%h (%0d,%0d) last=%b, want pix=%h (%0d,%0d) last=%b",
                                      out_pixel_out, out_row, out_col, out_last_of_run,
                                      wd.pix, wd.row, wd.col, wd.last));
        end
      end
    end
    pending = expected_pix.size();
  end
endmodule

/* bench/tb_bayer_lch_highlight_rebuild.sv */
// Top of the highlight rebuild bench: clock, reset, stimulus, receiver stalls and verdict.
module tb_bayer_lch_highlight_rebuild;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE = 60;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_frame_start;
  logic [19:0] in_pixel_value;
  logic        out_valid, out_ready, out_last_of_run;
  logic [19:0] out_pixel_out;
  logic [11:0] out_row, out_col;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;
  int          send_idle, recv_idle, hold_cnt, quiet_cycles;
  bit          hold_go, hold_done;
  logic [19:0] clip_now;

  bayer_lch_highlight_rebuild u_dut (.*);

  blhr_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_pixel_value, .in_frame_start,
    .out_valid, .out_ready, .out_pixel_out, .out_row, .out_col, .out_last_of_run,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    out_ready = 1'b0; hold_cnt = 0; hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1; hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** bayer_lch_highlight_rebuild: FAILED **");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
    if (idx == blhr_pkg::REG_CLIP) clip_now = data[19:0];
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_pix(input logic [19:0] v, input logic fs);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_pixel_value <= v; in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [19:0] pick_pix();
    int unsigned c;
    c = clip_now;
    case ($urandom_range(0, 3))
      0: return 20'($urandom);
      1: return 20'($urandom_range(0, c));
      2: return (c + 4 > 20'hFFFFF) ? 20'hFFFFF - 20'($urandom_range(0, 4))
                                    : 20'(c + $urandom_range(0, 8) - (c >= 4 ? 4 : 0));
      default: return 20'($urandom_range(c, 20'hFFFFF));
    endcase
  endfunction

  task automatic send_block(input logic [19:0] a, input logic [19:0] b,
                            input logic [19:0] c, input logic [19:0] d);
    send_pix(a, 1'b1); send_pix(b, 1'b0); send_pix(c, 1'b0); send_pix(d, 1'b0);
  endtask

  task automatic random_config;
    case ($urandom_range(0, 2))
      0: cfg_write(blhr_pkg::REG_CLIP, 32'h0);
      1: cfg_write(blhr_pkg::REG_CLIP, 32'hFFFFF);
      default: cfg_write(blhr_pkg::REG_CLIP, $urandom_range(32'h4000, 32'h40000));
    endcase
    cfg_write(blhr_pkg::REG_WIDTH, $urandom_range(0, 16));
    cfg_write(blhr_pkg::REG_HEIGHT, $urandom_range(0, 5) == 0 ? 32'd8191 : $urandom_range(0, 6));
    cfg_write(blhr_pkg::REG_CFA, $urandom_range(0, 1) ? 32'(blhr_pkg::CFA_RST) : $urandom);
    cfg_write(blhr_pkg::REG_OFFX,
              $urandom_range(0, 3) == 0 ? 32'd4095 : $urandom_range(0, 4095));
    cfg_write(blhr_pkg::REG_OFFY,
              $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 4095));
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_pixel_value = '0; in_frame_start = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle = 31; recv_idle = 71; hold_go = 0; clip_now = blhr_pkg::CLIP_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_write(blhr_pkg::REG_WIDTH, 32'd16);
    cfg_write(blhr_pkg::REG_HEIGHT, 32'd3);
    for (int i = 0; i < 16; i++) send_pix(pick_pix(), i == 0);
    drain();

    cfg_write(blhr_pkg::REG_WIDTH, 32'd1);
    cfg_write(blhr_pkg::REG_HEIGHT, 32'd0);
    send_block(20'hFFFFF, 20'h0, 20'h10000, 20'hFFFFF);
    send_block(20'h20000, 20'h20000, 20'h20000, 20'h20000);
    drain();
    cfg_write(blhr_pkg::REG_CFA, 32'hFFFF_FFFF);
    send_block(20'h30000, 20'h1, 20'h2, 20'h3);
    drain();
    cfg_write(blhr_pkg::REG_CFA, 32'h5555_5555);
    send_block(20'hFFFFF, 20'h8000, 20'h0, 20'h40000);
    drain();
    cfg_write(blhr_pkg::REG_CFA, blhr_pkg::CFA_RST);
    cfg_write(blhr_pkg::REG_OFFX, 32'd4095);
    cfg_write(blhr_pkg::REG_OFFY, 32'd4095);
    cfg_write(blhr_pkg::REG_WIDTH, 32'd8191);
    cfg_write(blhr_pkg::REG_HEIGHT, 32'd8191);
    for (int i = 0; i < 20; i++) send_pix(pick_pix(), i == 0);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = mode == 0 ? 31 : (mode == 1 ? 71 : 0);
      recv_idle = mode == 0 ? 71 : (mode == 1 ? 31 : 0);
      for (int sub = 0; sub < 2; sub++) begin
        random_config();
        if (mode == 2 && sub == 0) hold_go = 1;
        for (int i = 0; i < 17; i++)
          send_pix(pick_pix(), (i == 0 && $urandom_range(0, 1)) || $urandom_range(0, 99) < 3);
        drain();
      end
    end

    if (fail_count == 0) $display("** bayer_lch_highlight_rebuild: PASSED **");
    else $display("** bayer_lch_highlight_rebuild: FAILED **");
    $finish;
  end
endmodule

/* bayer_lch_highlight_rebuild.f */
src/blhr_pkg.sv
src/blhr_ram.sv
src/bayer_lch_highlight_rebuild.sv
bench/blhr_checker.sv
bench/tb_bayer_lch_highlight_rebuild.sv
